// File: rtl/core/ccg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccg_pkg;

    // Pixel word widths
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 10;               // b + g + r, up to 765
    localparam int NUM_W     = 16;               // c * 255, up to 65025
    localparam int QUO_W     = 8;                // normalised channel
    localparam int DIVD_W    = SUM_W + QUO_W - 1; // sum shifted by the top quotient bit
    localparam int PROD_W    = SUM_W + CHAN_W;   // limit * sum
    localparam int NUM_LANES = 3;                // blue, green, red

    // Division: quotient bits retired per pipeline stage
    localparam int DIV_BITS_PER_STG = 2;
    localparam int DIV_STAGES       = QUO_W / DIV_BITS_PER_STG;

    // Lane positions
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT  = 1'd1;

    localparam logic [CHAN_W-1:0] GREEN_LIMIT_RST = 8'd80;
    localparam logic [CHAN_W-1:0] BLUE_LIMIT_RST  = 8'd108;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
        logic              kept;
    } pixel_out_t;

    typedef logic [NUM_W-1:0] lane_rem_t [NUM_LANES];
    typedef logic [QUO_W-1:0] lane_quo_t [NUM_LANES];

endpackage

`default_nettype wire

// File: rtl/core/chromaticity_color_gate_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  pixel_in_t  (blue, green, red)
// m_        out        m_valid / m_ready  pixel_out_t (normalised b, g, r, kept)
// cfg_      in         cfg_we             cfg_index selects limit, cfg_wdata
//
// One word per clock sustained while m_ready is high; the stages are a sum stage, four
// restoring division stages of two quotient bits each, and a rounding/output stage.
// Stages take a new word each clock unless stalled; dividers retire two bits a stage.
// aresetn is synchronous, active low: clears all valid bits, limits return to 80 / 108.
// Each stage holds its word until the next one can take it, so a stall on m_ready
// fills bubbles first and only then holds s_ready low.

module chromaticity_color_gate_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire ccg_pkg::pixel_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output ccg_pkg::pixel_out_t                   m_data,
    input  wire logic                             cfg_we,
    input  wire logic [ccg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ccg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ccg_pkg::*;

    localparam int NSTG = DIV_STAGES + 2;

    // Limits
    logic [CHAN_W-1:0] green_limit_reg;
    logic [CHAN_W-1:0] blue_limit_reg;

    // Pipeline control
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] load;

    // Stage 0: sum and scaled numerators
    logic [SUM_W-1:0] sum0_reg;
    lane_rem_t        num0_reg;

    // Division stages
    logic [SUM_W-1:0] dsum_reg  [DIV_STAGES];
    lane_rem_t        rem_reg   [DIV_STAGES];
    lane_quo_t        quo_reg   [DIV_STAGES];
    logic             keep_reg  [DIV_STAGES];

    lane_rem_t        rem_next  [DIV_STAGES];
    lane_quo_t        quo_next  [DIV_STAGES];
    logic             keep_next;

    // Output stage
    pixel_out_t out_reg;
    pixel_out_t out_next;

    logic [CHAN_W-1:0] chan_in [NUM_LANES];
    logic [SUM_W-1:0]  sum_next;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_limit_reg <= GREEN_LIMIT_RST;
            blue_limit_reg  <= BLUE_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GREEN_LIMIT: green_limit_reg <= cfg_wdata;
                CFG_BLUE_LIMIT:  blue_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Backward load chain: a stage loads when empty or when its word moves on
    always_comb begin
        load[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[NSTG-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: channel sum and c * 255 as (c << 8) - c
    always_comb begin
        chan_in[LANE_BLUE]  = s_data.blue_in;
        chan_in[LANE_GREEN] = s_data.green_in;
        chan_in[LANE_RED]   = s_data.red_in;
        sum_next = SUM_W'(s_data.blue_in) + SUM_W'(s_data.green_in)
                 + SUM_W'(s_data.red_in);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            sum0_reg <= sum_next;
            for (int l = 0; l < NUM_LANES; l++) begin
                num0_reg[l] <= {chan_in[l], {CHAN_W{1'b0}}} - NUM_W'(chan_in[l]);
            end
        end
    end

    // Limit tests on exact products, done alongside the first division stage
    always_comb begin
        logic [PROD_W-1:0] g_lim;
        logic [PROD_W-1:0] b_lim;
        g_lim = PROD_W'(green_limit_reg) * PROD_W'(sum0_reg);
        b_lim = PROD_W'(blue_limit_reg)  * PROD_W'(sum0_reg);
        keep_next = (sum0_reg != '0)
                 && (PROD_W'(num0_reg[LANE_GREEN]) <= g_lim)
                 && (PROD_W'(num0_reg[LANE_BLUE])  <= b_lim);
    end

    // Restoring division, two quotient bits per stage, three lanes in parallel
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [SUM_W-1:0] sum_in;
        lane_rem_t        rem_in;
        lane_quo_t        quo_in;
        logic             keep_in;

        if (j == 0) begin : g_first
            always_comb begin
                sum_in  = sum0_reg;
                rem_in  = num0_reg;
                keep_in = keep_next;
                for (int l = 0; l < NUM_LANES; l++) begin
                    quo_in[l] = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                sum_in  = dsum_reg[j-1];
                rem_in  = rem_reg[j-1];
                quo_in  = quo_reg[j-1];
                keep_in = keep_reg[j-1];
            end
        end

        always_comb begin
            logic [DIVD_W-1:0] rem_w;
            logic [DIVD_W-1:0] divr;
            logic [QUO_W-1:0]  q;
            for (int l = 0; l < NUM_LANES; l++) begin
                rem_w = DIVD_W'(rem_in[l]);
                q     = quo_in[l];
                for (int b = 0; b < DIV_BITS_PER_STG; b++) begin
                    divr = DIVD_W'(sum_in) << (QUO_W - 1 - j * DIV_BITS_PER_STG - b);
                    if (rem_w >= divr) begin
                        rem_w = rem_w - divr;
                        q[QUO_W - 1 - j * DIV_BITS_PER_STG - b] = 1'b1;
                    end
                end
                rem_next[j][l] = rem_w[NUM_W-1:0];
                quo_next[j][l] = q;
            end
        end

        always_ff @(posedge aclk) begin
            if (load[j+1]) begin
                dsum_reg[j] <= sum_in;
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
                keep_reg[j] <= keep_in;
            end
        end
    end

    // Output stage: round to nearest, ties to even; black when rejected
    always_comb begin
        logic [CHAN_W-1:0] res [NUM_LANES];
        logic [SUM_W:0]    twice;
        logic [SUM_W:0]    sum_w;
        logic [QUO_W:0]    rounded;
        logic              up;
        sum_w = (SUM_W+1)'(dsum_reg[DIV_STAGES-1]);
        for (int l = 0; l < NUM_LANES; l++) begin
            // remainder is below sum, so doubling fits in SUM_W + 1 bits
            twice = {rem_reg[DIV_STAGES-1][l][SUM_W-1:0], 1'b0};
            up = (twice > sum_w) || ((twice == sum_w) && quo_reg[DIV_STAGES-1][l][0]);
            rounded = (QUO_W+1)'(quo_reg[DIV_STAGES-1][l]) + (QUO_W+1)'(up);
            res[l] = keep_reg[DIV_STAGES-1] ? rounded[CHAN_W-1:0] : '0;
        end
        out_next.blue_out  = res[LANE_BLUE];
        out_next.green_out = res[LANE_GREEN];
        out_next.red_out   = res[LANE_RED];
        out_next.kept      = keep_reg[DIV_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        if (load[NSTG-1]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire
